[sv/riv_pkg.sv]
// Shared types and constants for the rank indexed vector.
// Used by riv_cell, riv_chain and rank_indexed_vector; no dependencies.
package riv_pkg;

    localparam int RANK_W  = 6;
    localparam int DATA_W  = 8;
    localparam int COUNT_W = 6;

    typedef enum logic [1:0] {
        MODE_READ    = 2'd0,
        MODE_REPLACE = 2'd1,
        MODE_INSERT  = 2'd2,
        MODE_REMOVE  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CMD_NONE   = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_INSERT = 2'd2,
        CMD_REMOVE = 2'd3
    } cmd_op_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        cmd_op_t             op;
        logic [RANK_W-1:0]   rank;
        logic [DATA_W-1:0]   value;
    } cell_cmd_t;

endpackage

[sv/riv_cell.sv]
// One storage cell of the rank chain: holds a byte and takes its neighbor's.
// Depends on riv_pkg.
module riv_cell #(
    parameter int INDEX = 0
) (
    input  logic                        clk,
    input  riv_pkg::cell_cmd_t          cmd,
    input  logic [riv_pkg::DATA_W-1:0]  left_data,
    input  logic [riv_pkg::DATA_W-1:0]  right_data,
    output logic [riv_pkg::DATA_W-1:0]  data
);

    logic [riv_pkg::DATA_W-1:0] data_reg;
    logic [riv_pkg::DATA_W-1:0] data_next;
    logic                       at_rank;
    logic                       above_rank;

    assign at_rank    = (INDEX == 32'(cmd.rank));
    assign above_rank = (INDEX > 32'(cmd.rank));

    always_comb
    begin
        data_next = data_reg;
        case (cmd.op)
            riv_pkg::CMD_WRITE:
            begin
                if (at_rank)
                    data_next = cmd.value;
            end
            riv_pkg::CMD_INSERT:
            begin
                if (above_rank)
                    data_next = left_data;
                else if (at_rank)
                    data_next = cmd.value;
            end
            riv_pkg::CMD_REMOVE:
            begin
                if (above_rank || at_rank)
                    data_next = right_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // Contents are undefined until written, so the cell has no reset.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

[sv/riv_chain.sv]
// Row of storage cells linked to their neighbors, with the read select by rank.
// Depends on riv_pkg and riv_cell.
module riv_chain #(
    parameter int CAPACITY = 32
) (
    input  logic                            clk,
    input  riv_pkg::cell_cmd_t              cmd,
    input  logic [$clog2(CAPACITY)-1:0]     read_index,
    output logic [riv_pkg::DATA_W-1:0]      read_data
);

    logic [riv_pkg::DATA_W-1:0] cell_data [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [riv_pkg::DATA_W-1:0] left_in;
        logic [riv_pkg::DATA_W-1:0] right_in;

        // The ends of the row never take a neighbor value that matters.
        if (i == 0)
        begin : g_first
            assign left_in = '0;
        end
        else
        begin : g_left
            assign left_in = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_in = '0;
        end
        else
        begin : g_right
            assign right_in = cell_data[i+1];
        end

        riv_cell #(
            .INDEX (i)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .left_data  (left_in),
            .right_data (right_in),
            .data       (cell_data[i])
        );
    end

    assign read_data = cell_data[read_index];

endmodule

[sv/rank_indexed_vector.sv]
// Rank indexed byte list built as a chain of shift cells.
// Throughput: one request per cycle while in_stall is low; every cell shifts in the same cycle.
// A two-entry output stage lets requests flow while one result waits.
// Reset clears the element count and the output stage; cell contents stay undefined.
module rank_indexed_vector #(
    parameter int CAPACITY = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      mode,
    input  logic [riv_pkg::RANK_W-1:0]      rank,
    input  logic [riv_pkg::DATA_W-1:0]      value,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [riv_pkg::DATA_W-1:0]      read_value,
    output logic [riv_pkg::COUNT_W-1:0]     element_count,
    output logic [1:0]                      status
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (CNT_W > riv_pkg::RANK_W) ? CNT_W : riv_pkg::RANK_W;

    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic [CMP_W-1:0]             rank_c;
    logic [CMP_W-1:0]             count_c;
    logic [CMP_W-1:0]             cap_c;
    logic                         in_range;
    logic                         accept;
    riv_pkg::mode_t               mode_op;
    riv_pkg::cell_cmd_t           cmd;
    riv_pkg::cmd_op_t             op_ok;
    riv_pkg::status_t             st;
    logic [riv_pkg::DATA_W-1:0]   chain_data;
    logic [riv_pkg::DATA_W-1:0]   rd;

    logic                         out_valid_reg;
    logic [riv_pkg::DATA_W-1:0]   out_value_reg;
    logic [riv_pkg::COUNT_W-1:0]  out_count_reg;
    riv_pkg::status_t             out_status_reg;
    logic                         skid_valid_reg;
    logic [riv_pkg::DATA_W-1:0]   skid_value_reg;
    logic [riv_pkg::COUNT_W-1:0]  skid_count_reg;
    riv_pkg::status_t             skid_status_reg;
    logic                         out_free;

    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !skid_valid_reg;
    assign mode_op  = riv_pkg::mode_t'(mode);

    assign rank_c   = CMP_W'(rank);
    assign count_c  = CMP_W'(count_reg);
    assign cap_c    = CMP_W'(CAPACITY);
    // The count never exceeds the capacity, so this also bounds the rank.
    assign in_range = (rank_c < count_c);

    always_comb
    begin
        count_next = count_reg;
        st         = riv_pkg::ST_OK;
        op_ok      = riv_pkg::CMD_NONE;
        rd         = '0;
        case (mode_op)
            riv_pkg::MODE_READ:
            begin
                if (in_range)
                    rd = chain_data;
                else
                    st = riv_pkg::ST_RANGE;
            end
            riv_pkg::MODE_REPLACE:
            begin
                if (in_range)
                    op_ok = riv_pkg::CMD_WRITE;
                else
                    st = riv_pkg::ST_RANGE;
            end
            riv_pkg::MODE_INSERT:
            begin
                if (rank_c > count_c)
                    st = riv_pkg::ST_RANGE;
                else if (count_c == cap_c)
                    st = riv_pkg::ST_FULL;
                else
                begin
                    op_ok      = riv_pkg::CMD_INSERT;
                    count_next = count_reg + 1'b1;
                end
            end
            default:
            begin
                if (count_reg == '0)
                    st = riv_pkg::ST_EMPTY;
                else if (!in_range)
                    st = riv_pkg::ST_RANGE;
                else
                begin
                    rd         = chain_data;
                    op_ok      = riv_pkg::CMD_REMOVE;
                    count_next = count_reg - 1'b1;
                end
            end
        endcase
    end

    assign cmd.op    = accept ? op_ok : riv_pkg::CMD_NONE;
    assign cmd.rank  = rank;
    assign cmd.value = value;

    riv_chain #(
        .CAPACITY (CAPACITY)
    ) u_chain (
        .clk        (clk),
        .cmd        (cmd),
        .read_index (rank_c[IDX_W-1:0]),
        .read_data  (chain_data)
    );

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                count_reg <= count_next;
            if (out_free)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                    out_valid_reg <= accept;
            end
            else if (accept)
                skid_valid_reg <= 1'b1;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_value_reg  <= skid_value_reg;
                out_count_reg  <= skid_count_reg;
                out_status_reg <= skid_status_reg;
            end
            else if (accept)
            begin
                out_value_reg  <= rd;
                out_count_reg  <= riv_pkg::COUNT_W'(count_next);
                out_status_reg <= st;
            end
        end
        else if (accept)
        begin
            skid_value_reg  <= rd;
            skid_count_reg  <= riv_pkg::COUNT_W'(count_next);
            skid_status_reg <= st;
        end
    end

    assign out_valid     = out_valid_reg;
    assign read_value    = out_value_reg;
    assign element_count = out_count_reg;
    assign status        = out_status_reg;

endmodule

[sim/tb.sv]
// Self-checking testbench for rank_indexed_vector: directed and random list requests.
// A scoreboard class predicts every result; plain tasks drive the request channel and an initial block the result side.
// Depends on riv_pkg and the rank_indexed_vector RTL only.
module tb;

    localparam int LIST_CAP    = 32;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 100;

    typedef struct packed {
        logic [riv_pkg::DATA_W-1:0]  read_value;
        logic [riv_pkg::COUNT_W-1:0] element_count;
        riv_pkg::status_t            status;
    } list_result_t;

    class list_tracker;
        logic [riv_pkg::DATA_W-1:0] bytes_held [LIST_CAP];
        int                         held_count;
        list_result_t               pending_results [$];
        int                         mismatches;

        function new();
            held_count = 0;
            mismatches = 0;
            for (int i = 0; i < LIST_CAP; i++)
                bytes_held[i] = '0;
        endfunction

        function int stored();
            return held_count;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Apply one accepted request to the shadow list and queue its result.
        function void note_request(riv_pkg::mode_t req_mode,
                                   logic [riv_pkg::RANK_W-1:0] req_rank,
                                   logic [riv_pkg::DATA_W-1:0] req_value);
            list_result_t res;
            int           pos;
            res.read_value = '0;
            res.status     = riv_pkg::ST_OK;
            pos            = int'(req_rank);
            case (req_mode)
                riv_pkg::MODE_READ:
                begin
                    if (pos < held_count)
                        res.read_value = bytes_held[pos];
                    else
                        res.status = riv_pkg::ST_RANGE;
                end
                riv_pkg::MODE_REPLACE:
                begin
                    if (pos < held_count)
                        bytes_held[pos] = req_value;
                    else
                        res.status = riv_pkg::ST_RANGE;
                end
                riv_pkg::MODE_INSERT:
                begin
                    // The range check takes priority over the full check.
                    if (pos > held_count)
                        res.status = riv_pkg::ST_RANGE;
                    else if (held_count >= LIST_CAP)
                        res.status = riv_pkg::ST_FULL;
                    else
                    begin
                        for (int i = held_count; i > pos; i--)
                            bytes_held[i] = bytes_held[i-1];
                        bytes_held[pos] = req_value;
                        held_count++;
                    end
                end
                default:
                begin
                    if (held_count == 0)
                        res.status = riv_pkg::ST_EMPTY;
                    else if (pos >= held_count)
                        res.status = riv_pkg::ST_RANGE;
                    else
                    begin
                        res.read_value = bytes_held[pos];
                        for (int i = pos; i + 1 < held_count; i++)
                            bytes_held[i] = bytes_held[i+1];
                        held_count--;
                    end
                end
            endcase
            res.element_count = riv_pkg::COUNT_W'(held_count);
            pending_results.push_back(res);
        endfunction

        function void check_result(logic [riv_pkg::DATA_W-1:0] got_value,
                                   logic [riv_pkg::COUNT_W-1:0] got_count,
                                   logic [1:0] got_status);
            list_result_t want;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: read_value=%0d element_count=%0d status=%0d",
                             got_value, got_count, got_status);
                return;
            end
            want = pending_results.pop_front();
            if (got_value !== want.read_value || got_count !== want.element_count ||
                got_status !== 2'(want.status))
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"Result mismatch: expected value=%0d count=%0d status=%0d,",
                              " got value=%0d count=%0d status=%0d"},
                             want.read_value, want.element_count, 2'(want.status),
                             got_value, got_count, got_status);
            end
        endfunction
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic [1:0]                   mode;
    logic [riv_pkg::RANK_W-1:0]   rank;
    logic [riv_pkg::DATA_W-1:0]   value;
    logic                         out_valid;
    logic                         out_stall;
    logic [riv_pkg::DATA_W-1:0]   read_value;
    logic [riv_pkg::COUNT_W-1:0]  element_count;
    logic [1:0]                   status;

    list_tracker tracker;
    int          in_idle_pct  = 0;
    int          stall_pct    = 0;
    bit          hold_off_req = 0;
    int          hold_left    = 0;
    int          cycle_count  = 0;

    rank_indexed_vector #(
        .CAPACITY(LIST_CAP)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .rank          (rank),
        .value         (value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .read_value    (read_value),
        .element_count (element_count),
        .status        (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input riv_pkg::mode_t req_mode,
                                input logic [riv_pkg::RANK_W-1:0] req_rank,
                                input logic [riv_pkg::DATA_W-1:0] req_value);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        mode     = req_mode;
        rank     = req_rank;
        value    = req_value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.note_request(req_mode, req_rank, req_value);
        @(negedge clk);
    endtask

    // Mostly well-formed ranks, with the operation mix steered by insert_pct.
    task automatic random_request(input int insert_pct);
        int                         cnt;
        int                         pick;
        riv_pkg::mode_t             req_mode;
        logic [riv_pkg::RANK_W-1:0] req_rank;
        cnt  = tracker.stored();
        pick = $urandom_range(99);
        if (pick < insert_pct)
            req_mode = riv_pkg::MODE_INSERT;
        else if (pick < 70)
            req_mode = riv_pkg::MODE_REMOVE;
        else if (pick < 85)
            req_mode = riv_pkg::MODE_READ;
        else
            req_mode = riv_pkg::MODE_REPLACE;
        if ($urandom_range(99) < 85)
        begin
            if (req_mode == riv_pkg::MODE_INSERT)
                req_rank = riv_pkg::RANK_W'($urandom_range(cnt));
            else
                req_rank = (cnt > 0) ? riv_pkg::RANK_W'($urandom_range(cnt - 1)) : '0;
        end
        else
            req_rank = riv_pkg::RANK_W'($urandom_range(63));
        send_request(req_mode, req_rank, riv_pkg::DATA_W'($urandom_range(255)));
    endtask

    task automatic run_phase(input int items, input int idle_pct, input int stall_chance,
                             input int hold_at);
        int bias;
        in_idle_pct = idle_pct;
        stall_pct   = stall_chance;
        for (int n = 0; n < items; n++)
        begin
            // Segments alternate between filling, draining and a balanced mix.
            case ((n / 80) % 3)
                0:       bias = 60;
                1:       bias = 10;
                default: bias = 35;
            endcase
            if (n == hold_at)
                hold_off_req = 1'b1;
            random_request(bias);
        end
    endtask

    // Result side: random stall, or a long hold-off when one is requested.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else
                out_stall = ($urandom_range(99) < stall_pct);
            @(posedge clk);
            if (out_valid && !out_stall)
                tracker.check_result(read_value, element_count, status);
        end
    end

    initial
    begin
        tracker   = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        mode      = '0;
        rank      = '0;
        value     = '0;
        out_stall = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty list, range errors, append, shifting insert and remove.
        send_request(riv_pkg::MODE_READ,    6'd0,  8'h00);
        send_request(riv_pkg::MODE_REMOVE,  6'd0,  8'h11);
        send_request(riv_pkg::MODE_REMOVE,  6'd63, 8'hFF);
        send_request(riv_pkg::MODE_REPLACE, 6'd0,  8'h22);
        send_request(riv_pkg::MODE_INSERT,  6'd1,  8'h33);
        send_request(riv_pkg::MODE_INSERT,  6'd0,  8'hFF);
        send_request(riv_pkg::MODE_INSERT,  6'd1,  8'h00);
        send_request(riv_pkg::MODE_INSERT,  6'd0,  8'hA5);
        send_request(riv_pkg::MODE_READ,    6'd0,  8'h00);
        send_request(riv_pkg::MODE_READ,    6'd1,  8'h00);
        send_request(riv_pkg::MODE_READ,    6'd2,  8'h00);
        send_request(riv_pkg::MODE_READ,    6'd3,  8'h00);
        send_request(riv_pkg::MODE_REPLACE, 6'd2,  8'h5A);
        send_request(riv_pkg::MODE_REPLACE, 6'd3,  8'h77);
        send_request(riv_pkg::MODE_INSERT,  6'd4,  8'h44);
        send_request(riv_pkg::MODE_REMOVE,  6'd1,  8'h00);
        send_request(riv_pkg::MODE_REMOVE,  6'd2,  8'h00);
        send_request(riv_pkg::MODE_READ,    6'd63, 8'h00);
        send_request(riv_pkg::MODE_READ,    6'd32, 8'h00);
        send_request(riv_pkg::MODE_INSERT,  6'd2,  8'hC3);
        send_request(riv_pkg::MODE_REMOVE,  6'd2,  8'h00);
        send_request(riv_pkg::MODE_READ,    6'd1,  8'h00);

        run_phase(410, 0,  0,  120);
        run_phase(410, 53, 0,  -1);
        run_phase(410, 0,  53, -1);
        run_phase(400, 16, 16, -1);
        in_valid = 1'b0;

        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
